// ===== hw/rtl/ieu_pkg.sv =====
// Package with operation codes, status codes and the queue entry type of the execute unit.
package ieu_pkg;

    // Operand and result width; the datapath is built for this width only.
    localparam int DATA_WIDTH = 64;

    typedef enum logic [5:0] {
        OP_ADD = 6'd0, OP_SUB = 6'd1, OP_MUL = 6'd2, OP_SDIV = 6'd3, OP_UDIV = 6'd4,
        OP_SMOD = 6'd5, OP_UMOD = 6'd6, OP_NEG = 6'd7, OP_AND = 6'd8, OP_OR = 6'd9,
        OP_XOR = 6'd10, OP_SHL = 6'd11, OP_LSHR = 6'd12, OP_ASHR = 6'd13, OP_NOT = 6'd14,
        OP_CLZ = 6'd15, OP_CTZ = 6'd16, OP_POPCNT = 6'd17, OP_EQ = 6'd18, OP_NE = 6'd19,
        OP_SLT = 6'd20, OP_ULT = 6'd21, OP_SLE = 6'd22, OP_ULE = 6'd23, OP_SGT = 6'd24,
        OP_UGT = 6'd25, OP_SGE = 6'd26, OP_UGE = 6'd27, OP_SADD_OVF = 6'd28,
        OP_SSUB_OVF = 6'd29, OP_SMUL_OVF = 6'd30, OP_UADD_OVF = 6'd31,
        OP_USUB_OVF = 6'd32, OP_UMUL_OVF = 6'd33, OP_SEXT = 6'd34, OP_ZEXT = 6'd35,
        OP_TRUNC = 6'd36, OP_INDEX = 6'd37, OP_SELECT = 6'd38
    } op_t;

    typedef enum logic [1:0] {
        ST_OK = 2'd0, ST_DIV0 = 2'd1, ST_MOD0 = 2'd2, ST_BADOP = 2'd3
    } status_t;

    // Classified instruction as it travels from the front end to the back end.
    typedef struct packed {
        logic [5:0]  op;
        logic        wide;
        logic        bad;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
    } entry_t;

endpackage

// ===== hw/rtl/ieu_front.sv =====
// Front end: accepts instructions, registers them and flags bad operation codes.
module ieu_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           valid,
    output logic           stall,
    input  logic [5:0]     operation,
    input  logic           wide,
    input  logic [63:0]    operand_a,
    input  logic [63:0]    operand_b,
    input  logic [63:0]    operand_c,
    output logic           q_valid,
    input  logic           q_stall,
    output ieu_pkg::entry_t q_entry
);
    import ieu_pkg::*;

    logic   full_reg;
    entry_t entry_reg;
    logic   take;

    assign stall   = full_reg && q_stall;
    assign take    = valid && !stall;
    assign q_valid = full_reg;
    assign q_entry = entry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else if (take)
        begin
            full_reg <= 1'b1;
        end
        else if (!q_stall)
        begin
            full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            entry_reg.op   <= operation;
            entry_reg.wide <= wide;
            entry_reg.bad  <= (operation > OP_SELECT);
            entry_reg.a    <= operand_a;
            entry_reg.b    <= operand_b;
            entry_reg.c    <= operand_c;
        end
    end

endmodule

// ===== hw/rtl/ieu_queue.sv =====
// Two-entry queue between front end and back end.
module ieu_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  ieu_pkg::entry_t in_entry,
    output logic            out_valid,
    input  logic            out_stall,
    output ieu_pkg::entry_t out_entry
);
    import ieu_pkg::*;

    entry_t     mem_reg [2];
    logic       wr_reg;
    logic       rd_reg;
    logic [1:0] cnt_reg;
    logic       push;
    logic       pop;

    assign in_stall  = (cnt_reg == 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_entry = mem_reg[rd_reg];
    assign push      = in_valid && !in_stall;
    assign pop       = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= !wr_reg;
            end
            if (pop)
            begin
                rd_reg <= !rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= in_entry;
        end
    end

endmodule

// ===== hw/rtl/ieu_divider.sv =====
// Pipelined radix-2 unsigned divider, one quotient bit per stage, with an enable for stalls.
module ieu_divider (
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] dividend,
    input  logic [63:0] divisor,
    output logic [63:0] quotient,
    output logic [63:0] remainder
);
    localparam int N = 64;

    logic [N-1:0] q_reg [N];
    logic [N-1:0] r_reg [N];
    logic [N-1:0] d_reg [N-1];

    for (genvar i = 0; i < N; i++)
    begin : g_stage
        logic [N-1:0] q_in;
        logic [N-1:0] r_in;
        logic [N-1:0] d_in;
        logic [N:0]   trial;
        logic [N:0]   diff;
        if (i == 0)
        begin : g_first
            assign q_in = dividend;
            assign r_in = '0;
            assign d_in = divisor;
        end
        else
        begin : g_next
            assign q_in = q_reg[i-1];
            assign r_in = r_reg[i-1];
            assign d_in = d_reg[i-1];
        end
        assign trial = {r_in, q_in[N-1]};
        assign diff  = trial - {1'b0, d_in};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!diff[N])
                begin
                    r_reg[i] <= diff[N-1:0];
                    q_reg[i] <= {q_in[N-2:0], 1'b1};
                end
                else
                begin
                    r_reg[i] <= trial[N-1:0];
                    q_reg[i] <= {q_in[N-2:0], 1'b0};
                end
            end
        end
        if (i < N - 1)
        begin : g_pass
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    d_reg[i] <= d_in;
                end
            end
        end
    end

    assign quotient  = q_reg[N-1];
    assign remainder = r_reg[N-1];

endmodule

// ===== hw/rtl/ieu_back.sv =====
// Back end: computes the result over a fixed pipeline that advances whenever the output moves.
module ieu_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    output logic            q_stall,
    input  ieu_pkg::entry_t q_entry,
    output logic            valid,
    input  logic            stall,
    output logic [63:0]     result,
    output logic [1:0]      status
);
    import ieu_pkg::*;

    // Stages 0..63 run beside the 64 divider stages (stage 0 also captures the
    // prepared instruction), then a two-stage tail: mul split and final select.
    localparam int DEPTH = 66;

    typedef struct packed {
        logic [5:0]  op;
        logic        wide;
        logic        bad;
        logic        sa;
        logic        sb;
        logic        bz;
        logic        minneg;
        logic [63:0] res;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
    } ctl_t;

    ctl_t        pipe_reg [DEPTH-2];
    logic        v_reg    [DEPTH];
    logic        en;
    logic        full_w;
    logic [63:0] mask;
    logic [63:0] top;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] ma;
    logic [63:0] mb;
    logic [5:0]  sh;
    logic [63:0] simple;
    logic [6:0]  lz;
    logic [6:0]  tz;
    logic [6:0]  pc;
    logic [63:0] quo;
    logic [63:0] rem;
    logic [63:0] dv_a;
    logic [63:0] dv_b;
    logic        signed_op;

    assign en      = !(valid && stall);
    assign q_stall = !en;

    // Extension, truncation, index and select always work on the full operands.
    assign full_w = q_entry.wide || (q_entry.op > OP_UMUL_OVF);
    assign mask = full_w ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0000_0000_FFFF_FFFF;
    assign top  = full_w ? 64'h8000_0000_0000_0000 : 64'h0000_0000_8000_0000;
    assign a    = q_entry.a & mask;
    assign b    = q_entry.b & mask;
    assign sh   = q_entry.wide ? b[5:0] : {1'b0, b[4:0]};
    assign ma   = ((a & top) != 0) ? ((64'd0 - a) & mask) : a;
    assign mb   = ((b & top) != 0) ? ((64'd0 - b) & mask) : b;

    always_comb
    begin
        lz = 7'd0;
        tz = 7'd0;
        pc = 7'd0;
        for (int i = 0; i < 64; i++)
        begin
            pc = pc + {6'd0, a[i]};
        end
        for (int i = 0; i < 64; i++)
        begin
            if (a[i] && (q_entry.wide || i < 32))
            begin
                lz = q_entry.wide ? 7'(63 - i) : 7'(31 - i);
            end
        end
        if (a == 0)
        begin
            lz = q_entry.wide ? 7'd64 : 7'd32;
        end
        tz = q_entry.wide ? 7'd64 : 7'd32;
        for (int i = 63; i >= 0; i--)
        begin
            if (a[i])
            begin
                tz = 7'(i);
            end
        end
    end

    always_comb
    begin
        simple = '0;
        unique case (q_entry.op)
            OP_ADD:      simple = a + b;
            OP_SUB:      simple = a - b;
            OP_NEG:      simple = 64'd0 - a;
            OP_AND:      simple = a & b;
            OP_OR:       simple = a | b;
            OP_XOR:      simple = a ^ b;
            OP_SHL:      simple = a << sh;
            OP_LSHR:     simple = a >> sh;
            OP_ASHR:     simple = ((a & top) != 0) ? ((a >> sh) | ~(mask >> sh)) : (a >> sh);
            OP_NOT:      simple = ~a;
            OP_CLZ:      simple = {57'd0, lz};
            OP_CTZ:      simple = {57'd0, tz};
            OP_POPCNT:   simple = {57'd0, pc};
            OP_EQ:       simple = {63'd0, a == b};
            OP_NE:       simple = {63'd0, a != b};
            OP_SLT:      simple = {63'd0, (a ^ top) < (b ^ top)};
            OP_ULT:      simple = {63'd0, a < b};
            OP_SLE:      simple = {63'd0, (a ^ top) <= (b ^ top)};
            OP_ULE:      simple = {63'd0, a <= b};
            OP_SGT:      simple = {63'd0, (a ^ top) > (b ^ top)};
            OP_UGT:      simple = {63'd0, a > b};
            OP_SGE:      simple = {63'd0, (a ^ top) >= (b ^ top)};
            OP_UGE:      simple = {63'd0, a >= b};
            OP_SADD_OVF: simple = {63'd0, ((~(a ^ b)) & (a ^ ((a + b) & mask)) & top) != 0};
            OP_SSUB_OVF: simple = {63'd0, ((a ^ b) & (a ^ ((a - b) & mask)) & top) != 0};
            OP_UADD_OVF: simple = {63'd0, ((a + b) & mask) < a};
            OP_USUB_OVF: simple = {63'd0, a < b};
            OP_SEXT:     simple = {{32{q_entry.a[31]}}, q_entry.a[31:0]};
            OP_ZEXT:     simple = {32'd0, q_entry.a[31:0]};
            OP_TRUNC:    simple = {56'd0, q_entry.a[7:0]};
            OP_SELECT:   simple = (q_entry.a != 0) ? q_entry.b : q_entry.c;
            default:     simple = '0;
        endcase
    end

    assign signed_op = (q_entry.op == OP_SDIV) || (q_entry.op == OP_SMOD);
    assign dv_a = signed_op ? ma : a;
    assign dv_b = signed_op ? mb : b;

    ieu_divider u_div (
        .clk       (clk),
        .en        (en),
        .dividend  (dv_a),
        .divisor   (dv_b),
        .quotient  (quo),
        .remainder (rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                v_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            v_reg[0] <= q_valid;
            for (int i = 1; i < DEPTH; i++)
            begin
                v_reg[i] <= v_reg[i-1];
            end
        end
    end

    // Product pieces for mul, index and the overflow checks (32x32 each).
    logic [63:0] pll_reg, plh_reg, phl_reg, phh_reg;
    logic [63:0] ill_reg, ilh_reg, ihl_reg;
    logic [63:0] sll_reg, slh_reg, shl_reg, shh_reg;
    logic [63:0] qd_reg, rd_reg;
    ctl_t        tail_reg;
    logic [63:0] res_reg;
    logic [1:0]  st_reg;

    // The last control stage lines up with the divider output.
    ctl_t        last;
    assign last = pipe_reg[DEPTH-3];

    logic [63:0] mx;
    logic [63:0] my;
    assign mx = last.sa ? ((64'd0 - last.a) & (last.wide ? 64'hFFFF_FFFF_FFFF_FFFF
                : 64'h0000_0000_FFFF_FFFF)) : last.a;
    assign my = last.sb ? ((64'd0 - last.b) & (last.wide ? 64'hFFFF_FFFF_FFFF_FFFF
                : 64'h0000_0000_FFFF_FFFF)) : last.b;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pipe_reg[0].op     <= q_entry.op;
            pipe_reg[0].wide   <= q_entry.wide;
            pipe_reg[0].bad    <= q_entry.bad;
            pipe_reg[0].sa     <= (a & top) != 0;
            pipe_reg[0].sb     <= (b & top) != 0;
            pipe_reg[0].bz     <= (b == 0);
            pipe_reg[0].minneg <= (a == top) && (b == mask);
            pipe_reg[0].res    <= simple;
            pipe_reg[0].a      <= a;
            pipe_reg[0].b      <= b;
            pipe_reg[0].c      <= q_entry.c;
            for (int i = 1; i < DEPTH - 2; i++)
            begin
                pipe_reg[i] <= pipe_reg[i-1];
            end
            tail_reg <= last;
            qd_reg   <= quo;
            rd_reg   <= rem;
            pll_reg  <= last.a[31:0] * last.b[31:0];
            plh_reg  <= last.a[31:0] * last.b[63:32];
            phl_reg  <= last.a[63:32] * last.b[31:0];
            phh_reg  <= last.a[63:32] * last.b[63:32];
            ill_reg  <= last.b[31:0] * last.c[31:0];
            ilh_reg  <= last.b[31:0] * last.c[63:32];
            ihl_reg  <= last.b[63:32] * last.c[31:0];
            sll_reg  <= mx[31:0] * my[31:0];
            slh_reg  <= mx[31:0] * my[63:32];
            shl_reg  <= mx[63:32] * my[31:0];
            shh_reg  <= mx[63:32] * my[63:32];
        end
    end

    // Final stage: assemble products and division results.
    logic [63:0]  mk;
    logic [63:0]  tp;
    logic [127:0] uprod;
    logic [127:0] sprod;
    logic [63:0]  prod;
    logic [63:0]  idx;
    logic [63:0]  fin;
    logic [1:0]   fst;
    logic         uovf;
    logic         sovf;
    logic [127:0] slim;

    assign mk = tail_reg.wide ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0000_0000_FFFF_FFFF;
    assign tp = tail_reg.wide ? 64'h8000_0000_0000_0000 : 64'h0000_0000_8000_0000;
    assign uprod = {64'd0, pll_reg} + {32'd0, plh_reg, 32'd0} + {32'd0, phl_reg, 32'd0}
                 + {phh_reg, 64'd0};
    assign sprod = {64'd0, sll_reg} + {32'd0, slh_reg, 32'd0} + {32'd0, shl_reg, 32'd0}
                 + {shh_reg, 64'd0};
    assign prod = uprod[63:0];
    assign idx  = tail_reg.a + ill_reg + {ilh_reg[31:0], 32'd0} + {ihl_reg[31:0], 32'd0};
    assign uovf = tail_reg.wide ? (uprod[127:64] != 0) : (uprod[63:32] != 0);
    assign slim = (tail_reg.sa != tail_reg.sb) ? {64'd0, tp} : {64'd0, tp - 64'd1};
    assign sovf = sprod > slim;

    always_comb
    begin
        fin = tail_reg.res;
        fst = ST_OK;
        if (tail_reg.bad)
        begin
            fin = '0;
            fst = ST_BADOP;
        end
        else
        begin
            unique case (tail_reg.op)
                OP_MUL:      fin = prod & mk;
                OP_SMUL_OVF: fin = {63'd0, sovf};
                OP_UMUL_OVF: fin = {63'd0, uovf};
                OP_INDEX:    fin = idx;
                OP_UDIV:     fin = qd_reg;
                OP_UMOD:     fin = rd_reg;
                OP_SDIV:     fin = tail_reg.minneg ? tail_reg.a
                                 : ((tail_reg.sa != tail_reg.sb) ? ((64'd0 - qd_reg) & mk)
                                 : qd_reg);
                OP_SMOD:     fin = tail_reg.minneg ? 64'd0
                                 : (tail_reg.sa ? ((64'd0 - rd_reg) & mk) : rd_reg);
                default:     fin = tail_reg.res;
            endcase
            if (tail_reg.bz && (tail_reg.op == OP_SDIV || tail_reg.op == OP_UDIV))
            begin
                fin = '0;
                fst = ST_DIV0;
            end
            if (tail_reg.bz && (tail_reg.op == OP_SMOD || tail_reg.op == OP_UMOD))
            begin
                fin = '0;
                fst = ST_MOD0;
            end
            if (tail_reg.op <= OP_UMUL_OVF)
            begin
                fin = fin & mk;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= fin;
            st_reg  <= fst;
        end
    end

    assign valid  = v_reg[DEPTH-1];
    assign result = res_reg;
    assign status = st_reg;

endmodule

// ===== hw/rtl/integer_execute_unit_core.sv =====
// Top level of the integer execute unit: front end, queue and back end.
//
//  channel | signals                                          | direction
//  input   | valid, stall, operation, wide, operand_a/b/c     | into the unit
//  output  | out_valid, out_stall, result, status             | out of the unit
//
// One transaction is accepted per cycle when nothing stalls. Every instruction
// passes through one front end register, one queue slot, 64 back end stages
// that run beside the pipelined divider (the first also captures the prepared
// instruction), one tail stage for the split multiplications and the output
// register. Reset is asynchronous and clears all valid flags. A stall at the
// output while a result is valid freezes the back end pipeline; the queue and
// the front end register absorb in-flight transactions before the input stalls.
module integer_execute_unit_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           valid,
    output logic                           stall,
    input  logic [5:0]                     operation,
    input  logic                           wide,
    input  logic [ieu_pkg::DATA_WIDTH-1:0] operand_a,
    input  logic [ieu_pkg::DATA_WIDTH-1:0] operand_b,
    input  logic [ieu_pkg::DATA_WIDTH-1:0] operand_c,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [ieu_pkg::DATA_WIDTH-1:0] result,
    output logic [1:0]                     status
);
    import ieu_pkg::*;

    // The datapath is built for the fixed 64-bit width of the package.
    entry_t f_entry;
    entry_t b_entry;
    logic   f_valid;
    logic   f_stall;
    logic   b_valid;
    logic   b_stall;

    ieu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid     (valid),
        .stall     (stall),
        .operation (operation),
        .wide      (wide),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .operand_c (operand_c),
        .q_valid   (f_valid),
        .q_stall   (f_stall),
        .q_entry   (f_entry)
    );

    ieu_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_stall  (f_stall),
        .in_entry  (f_entry),
        .out_valid (b_valid),
        .out_stall (b_stall),
        .out_entry (b_entry)
    );

    ieu_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (b_valid),
        .q_stall (b_stall),
        .q_entry (b_entry),
        .valid   (out_valid),
        .stall   (out_stall),
        .result  (result),
        .status  (status)
    );

endmodule

// ===== hw/rtl/ieu_checker.sv =====
// Port-level checker for the execute unit and its bind to the top level.
module ieu_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [63:0] result,
    input logic [1:0]  status
);
    import ieu_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result) && $stable(status))
        else $error("stalled result changed");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> result == 64'd0)
        else $error("error status with nonzero result");

    a_no_stall_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !stall)
        else $error("input stalled while output empty");

endmodule

bind integer_execute_unit_core ieu_checker u_ieu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .stall     (stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .result    (result),
    .status    (status)
);

// ===== test/tb.sv =====
// Self-checking testbench for the integer execute unit with a built-in result predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ieu_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 100;

    typedef struct packed {
        logic [63:0] value;
        logic [1:0]  code;
    } outcome_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        valid = 1'b0;
    logic        stall;
    logic [5:0]  operation = '0;
    logic        wide = 1'b0;
    logic [63:0] operand_a = '0;
    logic [63:0] operand_b = '0;
    logic [63:0] operand_c = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [63:0] result;
    logic [1:0]  status;

    // Expected outcomes in order of acceptance.
    outcome_t pending_outcomes[$];
    int mismatch_count = 0;
    int cycle_count = 0;
    int sink_wait = 0;
    bit sending_done = 1'b0;

    integer_execute_unit_core uut (
        .clk(clk), .rst_n(rst_n), .valid(valid), .stall(stall),
        .operation(operation), .wide(wide), .operand_a(operand_a),
        .operand_b(operand_b), .operand_c(operand_c), .out_valid(out_valid),
        .out_stall(out_stall), .result(result), .status(status)
    );

    always #1 clk = ~clk;

    // Leading zeros within the low w bits.
    function automatic logic [63:0] lead_zeros(logic [63:0] x, int w);
        int n;
        n = 0;
        for (int i = w - 1; i >= 0; i--)
        begin
            if (x[i]) break;
            n++;
        end
        return 64'(n);
    endfunction

    function automatic logic [63:0] trail_zeros(logic [63:0] x, int w);
        int n;
        n = 0;
        for (int i = 0; i < w; i++)
        begin
            if (x[i]) break;
            n++;
        end
        return 64'(n);
    endfunction

    // Signed quotient or remainder at width w, divisor nonzero.
    function automatic logic [63:0] signed_divide(logic [63:0] a, logic [63:0] b,
                                                  logic [63:0] mask, logic [63:0] top,
                                                  bit want_rem);
        logic [63:0] ma, mb, q, r;
        bit sa, sb;
        sa = (a & top) != 0;
        sb = (b & top) != 0;
        if (a == top && b == mask) return want_rem ? 64'd0 : a;
        ma = sa ? ((64'd0 - a) & mask) : a;
        mb = sb ? ((64'd0 - b) & mask) : b;
        q = ma / mb;
        r = ma % mb;
        if (want_rem) return sa ? ((64'd0 - r) & mask) : r;
        return (sa != sb) ? ((64'd0 - q) & mask) : q;
    endfunction

    function automatic logic [63:0] signed_mul_overflow(logic [63:0] a, logic [63:0] b,
                                                        logic [63:0] mask,
                                                        logic [63:0] top);
        logic [63:0] ma, mb, lim;
        bit sa, sb;
        sa = (a & top) != 0;
        sb = (b & top) != 0;
        ma = sa ? ((64'd0 - a) & mask) : a;
        mb = sb ? ((64'd0 - b) & mask) : b;
        lim = (sa != sb) ? top : top - 64'd1;
        if (ma == 0 && sa) ma = top;
        if (mb == 0 && sb) mb = top;
        if (mb == 0) return 64'd0;
        return (ma > lim / mb) ? 64'd1 : 64'd0;
    endfunction

    // Computes the result and status the unit must give for one instruction.
    function automatic outcome_t execute_instruction(logic [5:0] opc, logic wd,
                                                     logic [63:0] ra, logic [63:0] rb,
                                                     logic [63:0] rc);
        int w;
        logic [63:0] mask, top, a, b, sh, res, s;
        status_t st;
        outcome_t o;
        w = wd ? 64 : 32;
        mask = wd ? '1 : 64'h0000_0000_FFFF_FFFF;
        top = wd ? 64'h8000_0000_0000_0000 : 64'h0000_0000_8000_0000;
        a = ra & mask;
        b = rb & mask;
        sh = b & 64'(w - 1);
        res = '0;
        st = ST_OK;
        case (opc)
            OP_ADD: res = a + b;
            OP_SUB: res = a - b;
            OP_MUL: res = a * b;
            OP_SDIV: if (b == 0) st = ST_DIV0;
                     else res = signed_divide(a, b, mask, top, 1'b0);
            OP_UDIV: if (b == 0) st = ST_DIV0; else res = a / b;
            OP_SMOD: if (b == 0) st = ST_MOD0;
                     else res = signed_divide(a, b, mask, top, 1'b1);
            OP_UMOD: if (b == 0) st = ST_MOD0; else res = a % b;
            OP_NEG: res = 64'd0 - a;
            OP_AND: res = a & b;
            OP_OR: res = a | b;
            OP_XOR: res = a ^ b;
            OP_SHL: res = a << sh;
            OP_LSHR: res = a >> sh;
            OP_ASHR:
            begin
                res = a >> sh;
                if (a & top) res |= ~(mask >> sh);
            end
            OP_NOT: res = ~a;
            OP_CLZ: res = lead_zeros(a, w);
            OP_CTZ: res = trail_zeros(a, w);
            OP_POPCNT: res = 64'($countones(a));
            OP_EQ: res = {63'd0, a == b};
            OP_NE: res = {63'd0, a != b};
            OP_SLT: res = {63'd0, (a ^ top) < (b ^ top)};
            OP_ULT: res = {63'd0, a < b};
            OP_SLE: res = {63'd0, (a ^ top) <= (b ^ top)};
            OP_ULE: res = {63'd0, a <= b};
            OP_SGT: res = {63'd0, (a ^ top) > (b ^ top)};
            OP_UGT: res = {63'd0, a > b};
            OP_SGE: res = {63'd0, (a ^ top) >= (b ^ top)};
            OP_UGE: res = {63'd0, a >= b};
            OP_SADD_OVF:
            begin
                s = (a + b) & mask;
                res = {63'd0, (~(a ^ b) & (a ^ s) & top) != 0};
            end
            OP_SSUB_OVF:
            begin
                s = (a - b) & mask;
                res = {63'd0, ((a ^ b) & (a ^ s) & top) != 0};
            end
            OP_SMUL_OVF: res = signed_mul_overflow(a, b, mask, top);
            OP_UADD_OVF: res = {63'd0, ((a + b) & mask) < a};
            OP_USUB_OVF: res = {63'd0, a < b};
            OP_UMUL_OVF: res = {63'd0, (b != 0) && (a > mask / b)};
            OP_SEXT: res = {{32{ra[31]}}, ra[31:0]};
            OP_ZEXT: res = {32'd0, ra[31:0]};
            OP_TRUNC: res = {56'd0, ra[7:0]};
            OP_INDEX: res = ra + rb * rc;
            OP_SELECT: res = (ra != 0) ? rb : rc;
            default: st = ST_BADOP;
        endcase
        if (opc <= OP_UMUL_OVF) res &= mask;
        o.value = res;
        o.code = st;
        return o;
    endfunction

    // Appends one expected outcome behind the older ones.
    task automatic queue_expected(outcome_t o);
        pending_outcomes = {pending_outcomes, o};
    endtask

    // Sends one instruction after a random gap and records its expected outcome.
    task automatic send_instruction(logic [5:0] opc, logic wd, logic [63:0] ra,
                                    logic [63:0] rb, logic [63:0] rc);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        valid <= 1'b1;
        operation <= opc;
        wide <= wd;
        operand_a <= ra;
        operand_b <= rb;
        operand_c <= rc;
        do @(posedge clk); while (stall);
        queue_expected(execute_instruction(opc, wd, ra, rb, rc));
    endtask

    task automatic park_input();
        valid <= 1'b0;
        @(posedge clk);
    endtask

    // Operand values that sit on the edges of both widths, mixed with random values.
    function automatic logic [63:0] edge_value();
        case ($urandom_range(0, 13))
            0: return 64'd0;
            1: return 64'd1;
            2: return '1;
            3: return 64'h8000_0000_0000_0000;
            4: return 64'h7FFF_FFFF_FFFF_FFFF;
            5: return 64'h0000_0000_8000_0000;
            6: return 64'h0000_0000_7FFF_FFFF;
            7: return 64'h0000_0000_FFFF_FFFF;
            8: return 64'($urandom_range(0, 70));
            9: return 64'd0 - 64'($urandom_range(1, 70));
            10: return {$urandom(), 32'h0} >> $urandom_range(0, 63);
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    // Directed cases: every operation at one width (alternating by op code), extremes and corner cases.
    task automatic test_directed();
        for (int opc = 0; opc <= OP_SELECT; opc++)
            send_instruction(6'(opc), opc[0], '1, 64'h8000_0000_8000_0001, 64'd3);
        send_instruction(OP_SDIV, 1'b1, 64'h8000_0000_0000_0000, '1, 64'd0);
        send_instruction(OP_SMOD, 1'b1, 64'h8000_0000_0000_0000, '1, 64'd0);
        send_instruction(OP_SDIV, 1'b0, 64'h0000_0000_8000_0000, 64'hFFFF_FFFF, 64'd0);
        send_instruction(OP_SMOD, 1'b0, 64'h1234_5678_8000_0000, 64'h5_FFFF_FFFF, 64'd0);
        send_instruction(OP_UDIV, 1'b0, 64'd7, 64'hFFFF_FFFF_0000_0000, 64'd0);
        send_instruction(OP_UMOD, 1'b1, 64'd7, 64'd0, 64'd0);
        send_instruction(OP_SDIV, 1'b1, 64'd7, 64'd0, 64'd0);
        send_instruction(OP_SMOD, 1'b0, 64'd7, 64'd0, 64'd0);
        send_instruction(OP_CLZ, 1'b0, 64'd0, 64'd0, 64'd0);
        send_instruction(OP_CTZ, 1'b1, 64'd0, 64'd0, 64'd0);
        send_instruction(6'd39, 1'b1, '1, '1, '1);
        send_instruction(6'd63, 1'b0, 64'd0, 64'd0, 64'd0);
        send_instruction(OP_SHL, 1'b0, 64'd1, 64'd63, 64'd0);
        send_instruction(OP_ASHR, 1'b1, 64'h8000_0000_0000_0000, 64'd127, 64'd0);
        send_instruction(OP_INDEX, 1'b0, 64'h1234_5678_9ABC_DEF0, 64'h1_0000_0003,
                         64'h2_0000_0005);
    endtask

    // Random instructions, mostly valid op codes with edge-heavy operands.
    task automatic test_random(int count);
        logic [5:0] opc;
        for (int i = 0; i < count; i++)
        begin
            opc = ($urandom_range(0, 19) == 0) ? 6'($urandom_range(39, 63))
                                                : 6'($urandom_range(0, OP_SELECT));
            send_instruction(opc, 1'($urandom_range(0, 1)), edge_value(), edge_value(),
                             edge_value());
        end
    endtask

    // The sender holds off until the pipeline has fully drained, then sends 20 random instructions.
    task automatic test_drain_pause();
        park_input();
        while (pending_outcomes.size() != 0) @(posedge clk);
        test_random(20);
    endtask

    // Sink side: after each accepted result it waits a drawn number of cycles,
    // with stall-free stretches.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            sink_wait = 0;
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
                sink_wait = ((cycle_count / 2000) % 3 == 2) ? 0 : $urandom_range(0, 10);
            else if (sink_wait > 0)
                sink_wait--;
            out_stall <= (sink_wait > 0);
        end
    end

    // Compares every accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_outcomes.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result %h status %0d", result, status);
            end
            else
            begin
                want = pending_outcomes.pop_front();
                if (result !== want.value || status !== want.code)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected %h/%0d, got %h/%0d",
                                 want.value, want.code, result, status);
                end
            end
        end
    end

    // Cycle counter with a hard stop.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(650);
        test_drain_pause();
        test_random(650);
        park_input();
        while (pending_outcomes.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_outcomes.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
